### hw/rtl/nla_pkg.sv
// ----------------------------------------------------------------------------
// nla_pkg
// Shared types and codes for the nearest landmark association core.
// ----------------------------------------------------------------------------
package nla_pkg;

  // Command codes carried on the input channel.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } nla_state_e;

  // Control from the sequencer to the distance unit.
  typedef struct packed {
    logic start;  // clear the running minimum for a new query
    logic valid;  // the head cell presents a loaded entry this cycle
  } nla_dist_ctl_t;

  // Status from the distance unit back to the sequencer.
  typedef struct packed {
    logic busy;   // entries are still in flight in the pipeline
  } nla_dist_sts_t;

endpackage

### hw/rtl/nla_if.sv
// ----------------------------------------------------------------------------
// nla_in_if / nla_out_if
// Valid/ready channels for observation and landmark beats and for match beats.
// ----------------------------------------------------------------------------
interface nla_in_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic                         first_entry;
  logic [15:0]                  landmark_id;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;

  modport source (output valid, cmd, first_entry, landmark_id, pos_x, pos_y, input ready);
  modport sink   (input valid, cmd, first_entry, landmark_id, pos_x, pos_y, output ready);
endinterface

interface nla_out_if #(
  parameter int COORD_BITS = 24
);
  localparam int DistW = 2 * COORD_BITS + 1;

  logic             valid;
  logic             ready;
  logic [15:0]      match_id;
  logic             found;
  logic [DistW-1:0] best_dist_sq;

  modport source (output valid, match_id, found, best_dist_sq, input ready);
  modport sink   (input valid, match_id, found, best_dist_sq, output ready);
endinterface

### hw/rtl/nla_cell.sv
// ----------------------------------------------------------------------------
// nla_cell
// One landmark slot of the storage ring; loads an entry or takes its neighbor's.
// ----------------------------------------------------------------------------
module nla_cell #(
  parameter int CoordBits = 24
) (
  input  logic                 clk_i,
  input  logic                 shift_i,
  input  logic                 load_i,
  input  logic [CoordBits-1:0] load_x_i,
  input  logic [CoordBits-1:0] load_y_i,
  input  logic [15:0]          load_id_i,
  input  logic [CoordBits-1:0] nb_x_i,
  input  logic [CoordBits-1:0] nb_y_i,
  input  logic [15:0]          nb_id_i,
  output logic [CoordBits-1:0] x_o,
  output logic [CoordBits-1:0] y_o,
  output logic [15:0]          id_o
);

  logic [CoordBits-1:0] x_q, x_d;
  logic [CoordBits-1:0] y_q, y_d;
  logic [15:0]          id_q, id_d;

  // A load writes this slot; during a scan the ring turns by one slot.
  always_comb begin
    x_d  = x_q;
    y_d  = y_q;
    id_d = id_q;
    if (load_i) begin
      x_d  = load_x_i;
      y_d  = load_y_i;
      id_d = load_id_i;
    end else if (shift_i) begin
      x_d  = nb_x_i;
      y_d  = nb_y_i;
      id_d = nb_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    id_q <= id_d;
  end

  assign x_o  = x_q;
  assign y_o  = y_q;
  assign id_o = id_q;

endmodule

### hw/rtl/nla_dist.sv
// ----------------------------------------------------------------------------
// nla_dist
// Squared distance pipeline and running minimum at the head of the ring.
// ----------------------------------------------------------------------------
module nla_dist #(
  parameter int CoordBits = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  nla_pkg::nla_dist_ctl_t       ctl_i,
  output nla_pkg::nla_dist_sts_t       sts_o,
  input  logic [CoordBits-1:0]         qx_i,
  input  logic [CoordBits-1:0]         qy_i,
  input  logic [CoordBits-1:0]         ex_i,
  input  logic [CoordBits-1:0]         ey_i,
  input  logic [15:0]                  eid_i,
  output logic                         found_o,
  output logic [15:0]                  best_id_o,
  output logic [2*CoordBits:0]         best_dist_o
);
  import nla_pkg::*;

  localparam int SqW   = 2 * CoordBits;
  localparam int DistW = SqW + 1;

  // Stage one: absolute coordinate differences.
  logic                 s1_v_q;
  logic [CoordBits-1:0] dx_q, dy_q, dx_d, dy_d;
  logic [15:0]          s1_id_q;
  logic [CoordBits:0]   diff_x, diff_y;

  always_comb begin
    diff_x = {qx_i[CoordBits-1], qx_i} - {ex_i[CoordBits-1], ex_i};
    diff_y = {qy_i[CoordBits-1], qy_i} - {ey_i[CoordBits-1], ey_i};
    dx_d   = diff_x[CoordBits] ? CoordBits'(-diff_x) : diff_x[CoordBits-1:0];
    dy_d   = diff_y[CoordBits] ? CoordBits'(-diff_y) : diff_y[CoordBits-1:0];
  end

  // Stage two: the two squares.
  logic           s2_v_q;
  logic [SqW-1:0] sqx_q, sqy_q;
  logic [15:0]    s2_id_q;

  // Stage three: sum and strict compare against the running minimum.
  logic             any_q;
  logic [DistW-1:0] best_q;
  logic [15:0]      best_id_q;
  logic [DistW-1:0] sum;
  logic             take;

  assign sum  = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign take = s2_v_q && (!any_q || (sum < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      any_q  <= 1'b0;
    end else begin
      s1_v_q <= ctl_i.valid;
      s2_v_q <= s1_v_q;
      if (ctl_i.start) begin
        any_q <= 1'b0;
      end else if (take) begin
        any_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    s1_id_q <= eid_i;
    sqx_q   <= SqW'(dx_q) * SqW'(dx_q);
    sqy_q   <= SqW'(dy_q) * SqW'(dy_q);
    s2_id_q <= s1_id_q;
    if (ctl_i.start) begin
      best_q    <= '0;
      best_id_q <= '0;
    end else if (take) begin
      best_q    <= sum;
      best_id_q <= s2_id_q;
    end
  end

  assign sts_o.busy  = s1_v_q || s2_v_q;
  assign found_o     = any_q;
  assign best_id_o   = best_id_q;
  assign best_dist_o = best_q;

endmodule

### hw/rtl/nearest_landmark_association_core.sv
// ----------------------------------------------------------------------------
// nearest_landmark_association_core
// Nearest neighbor association of an observation against a landmark table.
// ----------------------------------------------------------------------------
// The landmark table lives in a ring of MAX_LANDMARKS cells. A load beat
// (cmd = 0) writes the next free cell; first_entry starts a new table, and
// loads into a full table are dropped. A query beat (cmd = 1) turns the ring
// one full revolution, so that each entry passes the single distance unit at
// the head once, and then waits for that unit's pipeline to drain. The input
// stays closed from the accept of a query until its match beat is written to
// the output register, which also waits for any earlier match beat in that
// register to be taken. The match beat carries the first entry at the
// smallest squared distance, or found = 0 with zero id and distance when the
// table is empty.
module nearest_landmark_association_core #(
  parameter int MAX_LANDMARKS = 64,
  parameter int COORD_BITS    = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nla_in_if.sink    meas_i,
  nla_out_if.source match_o
);
  import nla_pkg::*;

  localparam int IdxW  = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int CntW  = $clog2(MAX_LANDMARKS + 1);
  localparam int CmpW  = IdxW + CntW;
  localparam int DistW = 2 * COORD_BITS + 1;

  nla_state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] scan_q, scan_d;
  logic [COORD_BITS-1:0] qx_q, qy_q;

  logic accept, is_load, is_query, shift, drain_done;
  logic scan_last;

  nla_dist_ctl_t dist_ctl;
  nla_dist_sts_t dist_sts;

  assign meas_i.ready = (state_q == ST_IDLE);
  assign accept       = meas_i.valid && meas_i.ready;
  assign is_load      = accept && (meas_i.cmd == CMD_LOAD);
  assign is_query     = accept && (meas_i.cmd == CMD_QUERY);
  assign shift        = (state_q == ST_SCAN);
  assign scan_last    = (scan_q == IdxW'(MAX_LANDMARKS - 1));

  // Storage ring: cell k takes cell k+1, the last cell takes the head.
  logic [COORD_BITS-1:0] cx [MAX_LANDMARKS];
  logic [COORD_BITS-1:0] cy [MAX_LANDMARKS];
  logic [15:0]           cid[MAX_LANDMARKS];

  for (genvar k = 0; k < MAX_LANDMARKS; k++) begin : g_cell
    localparam int Nb = (k + 1) % MAX_LANDMARKS;
    logic load_here;

    assign load_here = is_load &&
                       (meas_i.first_entry ? (k == 0)
                                           : (count_q == CntW'(k)));

    nla_cell #(.CoordBits(COORD_BITS)) u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .load_i   (load_here),
      .load_x_i (meas_i.pos_x),
      .load_y_i (meas_i.pos_y),
      .load_id_i(meas_i.landmark_id),
      .nb_x_i   (cx[Nb]),
      .nb_y_i   (cy[Nb]),
      .nb_id_i  (cid[Nb]),
      .x_o      (cx[k]),
      .y_o      (cy[k]),
      .id_o     (cid[k])
    );
  end

  // Distance unit at the head of the ring.
  logic                  found;
  logic [15:0]           best_id;
  logic [DistW-1:0]      best_dist;

  assign dist_ctl.start = is_query;
  assign dist_ctl.valid = shift && (CmpW'(scan_q) < CmpW'(count_q));

  nla_dist #(.CoordBits(COORD_BITS)) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (dist_ctl),
    .sts_o      (dist_sts),
    .qx_i       (qx_q),
    .qy_i       (qy_q),
    .ex_i       (cx[0]),
    .ey_i       (cy[0]),
    .eid_i      (cid[0]),
    .found_o    (found),
    .best_id_o  (best_id),
    .best_dist_o(best_dist)
  );

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [15:0]      out_id_q;
  logic             out_found_q;
  logic [DistW-1:0] out_dist_q;

  assign drain_done = (state_q == ST_DRAIN) && !dist_sts.busy &&
                      (!out_valid_q || match_o.ready);

  // Sequencer, fill count and scan position.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    out_valid_d = out_valid_q;
    if (match_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        scan_d = '0;
        if (is_load) begin
          if (meas_i.first_entry) begin
            count_d = CntW'(1);
          end else if (count_q < CntW'(MAX_LANDMARKS)) begin
            count_d = count_q + CntW'(1);
          end
        end
        if (is_query) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_d = scan_q + IdxW'(1);
        if (scan_last) begin
          scan_d  = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Query point and result payload.
  always_ff @(posedge clk_i) begin
    if (is_query) begin
      qx_q <= meas_i.pos_x;
      qy_q <= meas_i.pos_y;
    end
    if (drain_done) begin
      out_id_q    <= best_id;
      out_found_q <= found;
      out_dist_q  <= best_dist;
    end
  end

  assign match_o.valid        = out_valid_q;
  assign match_o.match_id     = out_id_q;
  assign match_o.found        = out_found_q;
  assign match_o.best_dist_sq = out_dist_q;

endmodule

### hw/rtl/nla_checker.sv
// ----------------------------------------------------------------------------
// nla_checker
// Port-level checks of the association core, bound to its top level.
// ----------------------------------------------------------------------------
module nla_checker #(
  parameter int COORD_BITS = 24
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  in_cmd_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [15:0]           out_match_id_i,
  input logic                  out_found_i,
  input logic [2*COORD_BITS:0] out_dist_i
);
  import nla_pkg::*;

  // A match beat that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("match beat dropped before it was taken");

  // A stalled match beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_match_id_i) && $stable(out_found_i) && $stable(out_dist_i))
    else $error("match payload changed while stalled");

  // An empty table gives zero id and zero distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> (out_match_id_i == 16'd0) && (out_dist_i == '0))
    else $error("empty-table match carries a nonzero id or distance");

  // A query beat starts a scan, so the input side closes right after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_cmd_i == CMD_QUERY) |=> !in_ready_i)
    else $error("input taken during a scan");

endmodule

bind nearest_landmark_association_core nla_checker #(
  .COORD_BITS(COORD_BITS)
) u_nla_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (meas_i.valid),
  .in_ready_i    (meas_i.ready),
  .in_cmd_i      (meas_i.cmd),
  .out_valid_i   (match_o.valid),
  .out_ready_i   (match_o.ready),
  .out_match_id_i(match_o.match_id),
  .out_found_i   (match_o.found),
  .out_dist_i    (match_o.best_dist_sq)
);

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest landmark association core. Landmark
// loads and observation queries are sent on the input channel, first from a
// short table of directed beats and then as random loads, queries and noise beats.
// A local predictor keeps its own copy of the landmark table and works out
// each match beat, which is compared field by field as it leaves the core.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nla_pkg::*;

  localparam int MaxLandmarks = 64;
  localparam int CoordBits    = 24;
  localparam int DistBits     = 2 * CoordBits + 1;
  localparam int ScanCycles   = MaxLandmarks + 3;
  localparam int TailCycles   = 2 * ScanCycles;
  localparam int RandomItems  = 1300;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct {
    logic        cmd;
    logic        first;
    logic [15:0] id;
    coord_t      x;
    coord_t      y;
  } beat_t;

  typedef struct {
    logic [15:0]         id;
    logic                found;
    logic [DistBits-1:0] dist_sq;
  } match_t;

  typedef struct {
    beat_t  beat;
    int     reps;
    bit     typed;
    match_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  nla_in_if  #(.COORD_BITS(CoordBits)) obs_if ();
  nla_out_if #(.COORD_BITS(CoordBits)) assoc_if ();

  nearest_landmark_association_core #(
    .MAX_LANDMARKS(MaxLandmarks),
    .COORD_BITS   (CoordBits)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .meas_i (obs_if),
    .match_o(assoc_if)
  );

  // Predicted landmark table and the matches still to come out.
  coord_t      lm_x  [MaxLandmarks];
  coord_t      lm_y  [MaxLandmarks];
  logic [15:0] lm_id [MaxLandmarks];
  int          lm_count;
  match_t      pending_matches[$];
  row_t        directed_rows[$];

  int errors;
  int items_sent;
  int send_calm;
  int recv_calm;
  int stall_left;
  int hold_left;
  bit hold_req;
  bit draining;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog.
  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t ns MISMATCH: %s", $time, what);
  endtask

  // Gap length for either side: mostly none or short, a few long, and
  // occasional calm stretches with no gaps at all.
  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Nearest landmark by squared distance; the first of equal minima wins.
  function automatic match_t nearest_match(input coord_t px, input coord_t py);
    match_t              m;
    longint              dx;
    longint              dy;
    logic [DistBits-1:0] d;
    m.id      = '0;
    m.found   = 1'b0;
    m.dist_sq = '0;
    for (int k = 0; k < lm_count; k++) begin
      dx = longint'(px) - longint'(lm_x[k]);
      dy = longint'(py) - longint'(lm_y[k]);
      d  = DistBits'(dx * dx + dy * dy);
      if (!m.found || d < m.dist_sq) begin
        m.id      = lm_id[k];
        m.found   = 1'b1;
        m.dist_sq = d;
      end
    end
    return m;
  endfunction

  // Offer one beat after a random gap and update the predictor once taken.
  task automatic offer_beat(input beat_t b, input bit typed, input match_t want);
    int     gap;
    match_t m;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      obs_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    obs_if.valid       <= 1'b1;
    obs_if.cmd         <= b.cmd;
    obs_if.first_entry <= b.first;
    obs_if.landmark_id <= b.id;
    obs_if.pos_x       <= b.x;
    obs_if.pos_y       <= b.y;
    do @(posedge clk_i); while (!obs_if.ready);
    if (b.cmd == CMD_LOAD) begin
      if (b.first) lm_count = 0;
      if (lm_count < MaxLandmarks) begin
        lm_x[lm_count]  = b.x;
        lm_y[lm_count]  = b.y;
        lm_id[lm_count] = b.id;
        lm_count++;
      end
    end else begin
      m = typed ? want : nearest_match(b.x, b.y);
      pending_matches = {pending_matches, m};
    end
    items_sent++;
  endtask

  task automatic add_row(input logic cmd, input logic first, input logic [15:0] id,
                         input coord_t x, input coord_t y, input int reps,
                         input bit typed, input logic [15:0] wid, input logic wfound,
                         input logic [DistBits-1:0] wdist);
    row_t r;
    r.beat.cmd     = cmd;
    r.beat.first   = first;
    r.beat.id      = id;
    r.beat.x       = x;
    r.beat.y       = y;
    r.reps         = reps;
    r.typed        = typed;
    r.want.id      = wid;
    r.want.found   = wfound;
    r.want.dist_sq = wdist;
    directed_rows = {directed_rows, r};
  endtask

  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return coord_t'($urandom());
    if (r < 70) return coord_t'($urandom_range(0, 4095) - 2048);
    if (r < 85) begin
      case ($urandom_range(0, 5))
        0:       return 24'sh800000;
        1:       return 24'sh7FFFFF;
        2:       return 24'sh800001;
        3:       return 24'sh7FFFFE;
        4:       return -24'sd1;
        default: return 24'sd0;
      endcase
    end
    return coord_t'($urandom_range(0, 63) * 256);
  endfunction

  // Query point: often close to a stored landmark, otherwise anywhere.
  function automatic beat_t rand_query();
    beat_t b;
    int    k;
    b.cmd   = CMD_QUERY;
    b.first = 1'($urandom_range(0, 1));
    b.id    = 16'($urandom_range(0, 65535));
    if (lm_count > 0 && $urandom_range(0, 1) == 1) begin
      k   = $urandom_range(0, lm_count - 1);
      b.x = lm_x[k] + coord_t'($urandom_range(0, 32) - 16);
      b.y = lm_y[k] + coord_t'($urandom_range(0, 32) - 16);
    end else begin
      b.x = rand_coord();
      b.y = rand_coord();
    end
    return b;
  endfunction

  function automatic beat_t rand_load(input logic first);
    beat_t b;
    b.cmd   = CMD_LOAD;
    b.first = first;
    b.id    = 16'($urandom_range(0, 65535));
    // Now and then repeat the previous position to set up ties.
    if (lm_count > 0 && $urandom_range(0, 9) == 0) begin
      b.x = lm_x[lm_count-1];
      b.y = lm_y[lm_count-1];
    end else begin
      b.x = rand_coord();
      b.y = rand_coord();
    end
    return b;
  endfunction

  // Match side: check each beat taken, then pick ready for the next cycle.
  initial begin
    assoc_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (assoc_if.valid && assoc_if.ready) begin
        if (pending_matches.size() == 0) begin
          report_mismatch($sformatf("match beat with none expected: id %h found %b dist %h",
                                    assoc_if.match_id, assoc_if.found,
                                    assoc_if.best_dist_sq));
        end else begin
          match_t want;
          want = pending_matches.pop_front();
          if (assoc_if.match_id !== want.id || assoc_if.found !== want.found ||
              assoc_if.best_dist_sq !== want.dist_sq) begin
            report_mismatch($sformatf("got id %h found %b dist %h, want id %h found %b dist %h",
                                      assoc_if.match_id, assoc_if.found,
                                      assoc_if.best_dist_sq, want.id, want.found,
                                      want.dist_sq));
          end
        end
      end
      if (hold_req) begin
        hold_left = 700;
        hold_req  = 1'b0;
      end
      if (draining) begin
        assoc_if.ready <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        assoc_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        assoc_if.ready <= 1'b0;
      end else begin
        stall_left = pick_gap(recv_calm);
        assoc_if.ready <= (stall_left == 0);
      end
    end
  end

  // Reset, directed table, random sequences, then drain and verdict.
  initial begin
    beat_t  b;
    match_t none;
    int     n;
    int     r;
    bit     held;
    bit     paused;

    errors       = 0;
    items_sent   = 0;
    lm_count     = 0;
    send_calm    = 0;
    recv_calm    = 0;
    stall_left   = 0;
    hold_left    = 0;
    hold_req     = 1'b0;
    draining     = 1'b0;
    held         = 1'b0;
    paused       = 1'b0;
    none.id      = '0;
    none.found   = 1'b0;
    none.dist_sq = '0;

    rst_ni             <= 1'b0;
    obs_if.valid       <= 1'b0;
    obs_if.cmd         <= CMD_LOAD;
    obs_if.first_entry <= 1'b0;
    obs_if.landmark_id <= '0;
    obs_if.pos_x       <= '0;
    obs_if.pos_y       <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table after reset, also with the ignored query fields set.
    add_row(CMD_QUERY, 1'b0, 16'h0000, 24'sd0, 24'sd0, 1, 1, 16'h0000, 1'b0, '0);
    add_row(CMD_QUERY, 1'b1, 16'hFFFF, 24'sh7FFFFF, 24'sh800000, 1, 1,
            16'h0000, 1'b0, '0);
    // One landmark at one meter.
    add_row(CMD_LOAD, 1'b1, 16'h1234, 24'sh000100, 24'sd0, 1, 0, '0, 1'b0, '0);
    add_row(CMD_QUERY, 1'b0, 16'h0000, 24'sd0, 24'sd0, 1, 1, 16'h1234, 1'b1, 49'd65536);
    // Equal distance on the other side: the earlier entry keeps the match.
    add_row(CMD_LOAD, 1'b0, 16'h0005, -24'sd256, 24'sd0, 1, 0, '0, 1'b0, '0);
    add_row(CMD_QUERY, 1'b0, 16'h0000, 24'sd0, 24'sd0, 1, 1, 16'h1234, 1'b1, 49'd65536);
    // A strictly closer later entry wins.
    add_row(CMD_LOAD, 1'b0, 16'hFFFF, 24'sd0, 24'sh000080, 1, 0, '0, 1'b0, '0);
    add_row(CMD_QUERY, 1'b0, 16'h0000, 24'sd0, 24'sd0, 1, 1, 16'hFFFF, 1'b1, 49'd16384);
    // first_entry on a query leaves the table alone.
    add_row(CMD_QUERY, 1'b1, 16'hAAAA, 24'sd0, 24'sd0, 1, 1, 16'hFFFF, 1'b1, 49'd16384);
    // Opposite corners give the largest distance, with id zero still found.
    add_row(CMD_LOAD, 1'b1, 16'h0000, 24'sh7FFFFF, 24'sh7FFFFF, 1, 0, '0, 1'b0, '0);
    add_row(CMD_QUERY, 1'b0, 16'h0000, 24'sh800000, 24'sh800000, 1, 1,
            16'h0000, 1'b1, 49'd562949886312450);
    // Fill the table, then a load into the full table is dropped.
    add_row(CMD_LOAD, 1'b1, 16'd100, 24'sd0, 24'sd0, 1, 0, '0, 1'b0, '0);
    add_row(CMD_LOAD, 1'b0, 16'd101, 24'sd1, 24'sd0, MaxLandmarks - 1, 0, '0, 1'b0, '0);
    add_row(CMD_LOAD, 1'b0, 16'hBEEF, -24'sd5, -24'sd5, 1, 0, '0, 1'b0, '0);
    add_row(CMD_QUERY, 1'b0, 16'h0000, -24'sd5, -24'sd5, 1, 1, 16'd100, 1'b1, 49'd50);
    add_row(CMD_QUERY, 1'b0, 16'h0000, 24'sd63, 24'sd0, 1, 1, 16'd163, 1'b1, 49'd0);
    // A new table started on a full one.
    add_row(CMD_LOAD, 1'b1, 16'h00AA, 24'sh800000, 24'sh7FFFFF, 1, 0, '0, 1'b0, '0);
    add_row(CMD_QUERY, 1'b0, 16'h0000, 24'sh7FFFFF, 24'sh800000, 1, 0, '0, 1'b0, '0);
    add_row(CMD_LOAD, 1'b0, 16'h5555, 24'sh123456, 24'shEDCBA9, 1, 0, '0, 1'b0, '0);
    add_row(CMD_QUERY, 1'b0, 16'h0000, 24'sh123450, 24'shEDCBA0, 1, 0, '0, 1'b0, '0);
    add_row(CMD_LOAD, 1'b0, 16'h0001, -24'sd1, -24'sd1, 1, 0, '0, 1'b0, '0);
    add_row(CMD_QUERY, 1'b0, 16'h0000, 24'sd0, 24'sd0, 1, 0, '0, 1'b0, '0);

    foreach (directed_rows[i]) begin
      for (int j = 0; j < directed_rows[i].reps; j++) begin
        b    = directed_rows[i].beat;
        b.id = b.id + 16'(j);
        b.x  = b.x + coord_t'(j);
        offer_beat(b, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Sender pause until the directed matches are all out.
    obs_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_matches.size() != 0);

    items_sent = 0;
    while (items_sent < RandomItems) begin
      // Long hold-off on the match side while loads and queries keep coming.
      if (!held && items_sent >= 400) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      // Sender pause until every pending match has been taken.
      if (!paused && items_sent >= 800) begin
        paused = 1'b1;
        obs_if.valid <= 1'b0;
        do @(posedge clk_i); while (pending_matches.size() != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 75) begin
        // New table with random content, then queries against it.
        r = $urandom_range(0, 9);
        if (r < 7) n = $urandom_range(1, 8);
        else if (r < 9) n = $urandom_range(9, 40);
        else n = $urandom_range(60, 70);
        for (int k = 0; k < n; k++) offer_beat(rand_load(k == 0), 0, none);
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) offer_beat(rand_query(), 0, none);
      end else if (r < 90) begin
        // Noise: one beat with every field random.
        b.cmd   = 1'($urandom_range(0, 1));
        b.first = 1'($urandom_range(0, 1));
        b.id    = 16'($urandom_range(0, 65535));
        b.x     = coord_t'($urandom());
        b.y     = coord_t'($urandom());
        offer_beat(b, 0, none);
      end else begin
        // Appends to the current table without a new start, then a query.
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) offer_beat(rand_load(1'b0), 0, none);
        offer_beat(rand_query(), 0, none);
      end
    end

    obs_if.valid <= 1'b0;
    draining = 1'b1;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### nearest_landmark_association_core.f
hw/rtl/nla_pkg.sv
hw/rtl/nla_if.sv
hw/rtl/nla_cell.sv
hw/rtl/nla_dist.sv
hw/rtl/nearest_landmark_association_core.sv
hw/rtl/nla_checker.sv
bench/tb.sv
